// ===== hw/rtl/gwm_pkg.sv =====
`timescale 1ns / 1ps

package gwm_pkg;

  // Pattern geometry
  localparam int PatternMax  = 32;
  localparam int PosW        = PatternMax + 1;
  localparam int LenW        = 6;
  localparam int WordW       = 64;
  localparam int NumPatWords = 4;
  localparam int CharW       = 8;
  localparam int CfgIdxW     = 3;
  localparam int PrefixLvls  = $clog2(PosW);

  localparam logic [CharW-1:0] StarChar  = 8'h2A;
  localparam logic [CharW-1:0] QueryChar = 8'h3F;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLength   = 3'd0,
    CfgBytes0_7 = 3'd1,
    CfgBytes8_15 = 3'd2,
    CfgBytes16_23 = 3'd3,
    CfgBytes24_31 = 3'd4
  } cfg_reg_e;

  typedef logic [PatternMax-1:0][CharW-1:0] pat_bytes_t;

  // Pattern setup handed to the step logic
  typedef struct packed {
    logic [LenW-1:0] len;
    pat_bytes_t      bytes;
  } pat_cfg_t;

endpackage

// ===== hw/rtl/gwm_step.sv =====
`timescale 1ns / 1ps

module gwm_step (
  input  logic [gwm_pkg::PosW-1:0]  active_i,
  input  gwm_pkg::pat_cfg_t         cfg_i,
  input  logic [gwm_pkg::CharW-1:0] char_i,
  output logic [gwm_pkg::PosW-1:0]  next_o,
  output logic                      matched_o
);
  import gwm_pkg::*;

  logic [PosW-1:0] lt_len;
  logic [PosW-1:0] le_len;
  logic [PosW-1:0] g_lvl [PrefixLvls+1];
  logic [PosW-1:0] p_lvl [PrefixLvls+1];
  logic [PosW-1:0] cur;

  // Position masks against the clamped length
  always_comb begin
    for (int i = 0; i < PosW; i++) begin
      lt_len[i] = (LenW'(i) < cfg_i.len);
      le_len[i] = (LenW'(i) <= cfg_i.len);
    end
  end

  // Star closure as a parallel prefix: a set bit runs up through every star
  always_comb begin
    g_lvl[0] = active_i & le_len;
    p_lvl[0] = '0;
    for (int i = 1; i < PosW; i++) begin
      p_lvl[0][i] = (cfg_i.bytes[i-1] == StarChar) && lt_len[i-1];
    end
    for (int l = 0; l < PrefixLvls; l++) begin
      for (int i = 0; i < PosW; i++) begin
        if (i >= (1 << l)) begin
          g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i-(1<<l)]);
          p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i-(1<<l)];
        end else begin
          g_lvl[l+1][i] = g_lvl[l][i];
          p_lvl[l+1][i] = p_lvl[l][i];
        end
      end
    end
  end

  assign cur       = g_lvl[PrefixLvls];
  assign matched_o = cur[cfg_i.len];

  // Advance by one name byte: star holds its position, others step on a hit
  always_comb begin
    next_o = '0;
    for (int i = 0; i < PatternMax; i++) begin
      if (cur[i] && lt_len[i]) begin
        if (cfg_i.bytes[i] == StarChar) begin
          next_o[i] = 1'b1;
        end else if (cfg_i.bytes[i] == QueryChar || cfg_i.bytes[i] == char_i) begin
          next_o[i+1] = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/glob_wildcard_matcher_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                                   Word
// s_axis    in   s_axis_tvalid/tready/tdata/tlast          one name byte, tlast ends the name
// m_axis    out  m_axis_tvalid/tready/tdata                one match flag per ended name
// cfg       in   cfg_valid_i/cfg_ready_o/cfg_index_i/data  one register write
//
// One word per cycle, but a stalled result holds the input register only
// when the word waiting there is another end of name; plain bytes keep
// flowing. A name byte is registered in the input register, then the
// prefix closure and advance in gwm_step update the position vector. An
// ending word passes the input register, then the result register. Reset
// sets the position vector to position zero and clears the pattern.

module glob_wildcard_matcher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream: tdata [7:0] name_char; tlast end_of_name
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Result stream: tdata [0] matched, [7:1] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,
  // Register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gwm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gwm_pkg::WordW-1:0]     cfg_data_i
);
  import gwm_pkg::*;

  logic [LenW-1:0]                  plen_q, plen_d;
  logic [NumPatWords-1:0][WordW-1:0] words_q, words_d;

  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q, in_char_d;
  logic             in_end_q, in_end_d;
  logic [PosW-1:0]  active_q, active_d;
  logic             out_valid_q, out_valid_d;
  logic             out_match_q, out_match_d;

  logic            s_accept;
  logic            fire;
  logic            cfg_we;
  pat_cfg_t        pat_cfg;
  logic [PosW-1:0] next_pos;
  logic            step_match;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Register decode; indexes past the list are dropped
  always_comb begin
    plen_d  = plen_q;
    words_d = words_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CfgLength:     plen_d     = cfg_data_i[LenW-1:0];
        CfgBytes0_7:   words_d[0] = cfg_data_i;
        CfgBytes8_15:  words_d[1] = cfg_data_i;
        CfgBytes16_23: words_d[2] = cfg_data_i;
        CfgBytes24_31: words_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the length to the pattern size
  assign pat_cfg.len   = (plen_q > LenW'(PatternMax)) ? LenW'(PatternMax) : plen_q;
  assign pat_cfg.bytes = pat_bytes_t'(words_q);

  // Process the held word unless it is an end of name facing a full result slot
  assign fire          = in_valid_q && (!in_end_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  gwm_step u_step (
    .active_i  (active_q),
    .cfg_i     (pat_cfg),
    .char_i    (in_char_q),
    .next_o    (next_pos),
    .matched_o (step_match)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    in_char_d   = in_char_q;
    in_end_d    = in_end_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;

    // Drop a delivered result first, then load a new one
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      in_valid_d = 1'b0;
      if (in_end_q) begin
        active_d    = PosW'(1);
        out_valid_d = 1'b1;
        out_match_d = step_match;
      end else begin
        active_d = next_pos;
      end
    end
    if (s_accept) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata;
      in_end_d   = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      words_q     <= '0;
      in_valid_q  <= 1'b0;
      active_q    <= PosW'(1);
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      words_q     <= words_d;
      in_valid_q  <= in_valid_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    in_char_q   <= in_char_d;
    in_end_q    <= in_end_d;
    out_match_q <= out_match_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_match_q};

endmodule

// ===== hw/rtl/gwm_checker.sv =====
`timescale 1ns / 1ps

module gwm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [2:0] pending_q, pending_d;
  logic       end_in;
  logic       res_out;

  assign end_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  // Track ended names whose flag is not yet delivered
  always_comb begin
    pending_d = pending_q + 3'(end_in) - 3'(res_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd0 |-> !m_axis_tvalid)
    else $error("result shown with no ended name pending");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more ended names in flight than stages");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
